// ----- rtl/running_median_two_heaps_assert.svh -----
// Assertion macros for the running median block checks
`ifndef RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RMTH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("running median check failed");

// next-cycle implication, checked outside reset
`define RMTH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("running median check failed");

`endif

// ----- rtl/rmth_pkg.sv -----
// Shared types and constants for the running median block
package rmth_pkg;

  localparam int unsigned CapacityDef    = 256;
  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned HeldWidth      = 9;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_REPLACE
  } rmth_op_e;

  typedef struct packed {
    rmth_op_e op;
    logic     clr;
  } rmth_ctl_t;

endpackage

// ----- rtl/rmth_cell.sv -----
// One cell of a sorted row: holds one sample and shifts with its neighbors
module rmth_cell #(
  parameter int unsigned SampleWidth = rmth_pkg::SampleWidthDef,
  parameter bit          IsMax       = 1'b1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmth_pkg::rmth_ctl_t           ctl_i,
  input  logic signed [SampleWidth-1:0] y_i,
  input  logic                          head_i,
  input  logic signed [SampleWidth-1:0] left_val_i,
  input  logic                          left_valid_i,
  input  logic                          left_take_i,
  input  logic signed [SampleWidth-1:0] right_val_i,
  input  logic                          right_take_i,
  output logic signed [SampleWidth-1:0] val_o,
  output logic                          valid_o,
  output logic                          take_o,
  output logic signed [SampleWidth-1:0] nxt_o
);
  import rmth_pkg::*;

  logic signed [SampleWidth-1:0] val_q, val_d;
  logic                          valid_q, valid_d;
  logic                          eff_valid;
  logic                          above;

  assign eff_valid = valid_q & ~ctl_i.clr;
  assign above     = IsMax ? (y_i > val_q) : (y_i < val_q);
  assign take_o    = ~eff_valid | above;
  assign val_o     = val_q;
  assign valid_o   = eff_valid;
  assign nxt_o     = val_d;

  always_comb begin
    val_d   = val_q;
    valid_d = eff_valid;
    case (ctl_i.op)
      OP_PUSH: begin
        if (take_o) begin
          val_d = left_take_i ? left_val_i : y_i;
        end
        valid_d = eff_valid | left_valid_i;
      end
      OP_REPLACE: begin
        if (right_take_i) begin
          val_d = (take_o && !head_i) ? val_q : y_i;
        end else begin
          val_d = right_val_i;
        end
      end
      default: begin
        val_d   = val_q;
        valid_d = eff_valid;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ----- rtl/rmth_chain.sv -----
// Row of sorted cells acting as one store, root in the first cell
module rmth_chain #(
  parameter int unsigned SampleWidth = rmth_pkg::SampleWidthDef,
  parameter int unsigned Depth       = (rmth_pkg::CapacityDef + 1) / 2,
  parameter bit          IsMax       = 1'b1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmth_pkg::rmth_ctl_t           ctl_i,
  input  logic signed [SampleWidth-1:0] y_i,
  output logic signed [SampleWidth-1:0] root_o,
  output logic signed [SampleWidth-1:0] root_nxt_o
);
  import rmth_pkg::*;

  logic signed [SampleWidth-1:0] val  [Depth];
  logic signed [SampleWidth-1:0] nxt  [Depth];
  logic                          vld  [Depth];
  logic                          take [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [SampleWidth-1:0] lval, rval;
    logic                          lvld, ltake, rtake;

    if (i == 0) begin : g_head
      assign lval  = y_i;
      assign lvld  = 1'b1;
      assign ltake = 1'b0;
    end else begin : g_body
      assign lval  = val[i-1];
      assign lvld  = vld[i-1];
      assign ltake = take[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign rval  = val[i];
      assign rtake = 1'b1;
    end else begin : g_inner
      assign rval  = val[i+1];
      assign rtake = take[i+1];
    end

    rmth_cell #(
      .SampleWidth (SampleWidth),
      .IsMax       (IsMax)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_i),
      .y_i          (y_i),
      .head_i       (i == 0),
      .left_val_i   (lval),
      .left_valid_i (lvld),
      .left_take_i  (ltake),
      .right_val_i  (rval),
      .right_take_i (rtake),
      .val_o        (val[i]),
      .valid_o      (vld[i]),
      .take_o       (take[i]),
      .nxt_o        (nxt[i])
    );
  end

  assign root_o     = val[0];
  assign root_nxt_o = nxt[0];

endmodule

// ----- rtl/running_median_two_heaps.sv -----
// Running median top level: two sorted cell rows with a registered result
// Takes one signed sample per transfer and returns the lower median of all samples held
// since the last restart, together with the held count and a drop flag. One input
// transfer is taken every cycle; its result appears in the output register in the cycle
// after acceptance and input keeps flowing while that register can drain. The samples
// live in two rows of (CAPACITY+1)/2 cells each, the lower half sorted with its maximum
// in the head cell and the upper half with its minimum there; each transfer inserts,
// or replaces the head and inserts, in every cell in parallel. The median is always a
// head cell, so no search over the rows is needed. Restart and reset take effect at
// once, with no clearing pass; once CAPACITY samples are held, further samples are
// dropped until a restart.
module running_median_two_heaps #(
  parameter int unsigned CAPACITY     = rmth_pkg::CapacityDef,
  parameter int unsigned SAMPLE_WIDTH = rmth_pkg::SampleWidthDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // sample
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
  // restart
  input  logic                                       s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // median, held
  output logic [((SAMPLE_WIDTH+rmth_pkg::HeldWidth+7)/8)*8-1:0] m_axis_tdata,
  // dropped
  output logic                                       m_axis_tuser
);
  import rmth_pkg::*;

  localparam int unsigned StoreDepth = (CAPACITY + 1) / 2;
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);
  localparam int unsigned TotW       = CntW + 1;
  localparam int unsigned OutW       = ((SAMPLE_WIDTH + HeldWidth + 7) / 8) * 8;

  logic signed [SAMPLE_WIDTH-1:0] x;
  logic                           restart;
  logic                           accept;

  logic [CntW-1:0] lc_q, lc_d, uc_q, uc_d, lc_eff, uc_eff;
  logic [TotW-1:0] tot_eff, tot_d;
  logic            full;
  logic            go_lower;

  rmth_ctl_t                      lo_ctl, up_ctl;
  logic signed [SAMPLE_WIDTH-1:0] lo_y, up_y;
  logic signed [SAMPLE_WIDTH-1:0] lo_root, up_root, lo_nxt, up_nxt;

  logic                           out_vld_q, out_vld_d;
  logic signed [SAMPLE_WIDTH-1:0] med_q, med_d;
  logic [HeldWidth-1:0]           held_q, held_d;
  logic                           drop_q, drop_d;

  assign x       = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign restart = s_axis_tuser;

  assign s_axis_tready = ~out_vld_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  assign lc_eff  = restart ? '0 : lc_q;
  assign uc_eff  = restart ? '0 : uc_q;
  assign tot_eff = TotW'(lc_eff) + TotW'(uc_eff);
  assign full    = tot_eff >= TotW'(CAPACITY);

  always_comb begin
    if (lc_eff == '0) begin
      go_lower = 1'b1;
    end else if (uc_eff == '0) begin
      go_lower = x < lo_root;
    end else begin
      go_lower = x < up_root;
    end
  end

  always_comb begin
    lo_ctl.op  = OP_NONE;
    lo_ctl.clr = accept & restart;
    up_ctl.op  = OP_NONE;
    up_ctl.clr = accept & restart;
    lo_y       = x;
    up_y       = x;
    lc_d       = lc_q;
    uc_d       = uc_q;
    drop_d     = drop_q;
    if (accept) begin
      lc_d   = lc_eff;
      uc_d   = uc_eff;
      drop_d = full;
      if (!full) begin
        if (go_lower) begin
          if (lc_eff > uc_eff) begin
            up_ctl.op = OP_PUSH;
            uc_d      = uc_eff + CntW'(1);
            if (x < lo_root) begin
              up_y      = lo_root;
              lo_ctl.op = OP_REPLACE;
            end
          end else begin
            lo_ctl.op = OP_PUSH;
            lc_d      = lc_eff + CntW'(1);
          end
        end else begin
          if (uc_eff > lc_eff) begin
            lo_ctl.op = OP_PUSH;
            lc_d      = lc_eff + CntW'(1);
            if (x > up_root) begin
              lo_y      = up_root;
              up_ctl.op = OP_REPLACE;
            end
          end else begin
            up_ctl.op = OP_PUSH;
            uc_d      = uc_eff + CntW'(1);
          end
        end
      end
    end
  end

  assign tot_d = TotW'(lc_d) + TotW'(uc_d);

  always_comb begin
    med_d     = med_q;
    held_d    = held_q;
    out_vld_d = out_vld_q;
    if (accept) begin
      med_d     = (lc_d < uc_d) ? up_nxt : lo_nxt;
      held_d    = HeldWidth'(tot_d);
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  rmth_chain #(
    .SampleWidth (SAMPLE_WIDTH),
    .Depth       (StoreDepth),
    .IsMax       (1'b1)
  ) u_lower (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lo_ctl),
    .y_i        (lo_y),
    .root_o     (lo_root),
    .root_nxt_o (lo_nxt)
  );

  rmth_chain #(
    .SampleWidth (SAMPLE_WIDTH),
    .Depth       (StoreDepth),
    .IsMax       (1'b0)
  ) u_upper (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (up_ctl),
    .y_i        (up_y),
    .root_o     (up_root),
    .root_nxt_o (up_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q      <= '0;
      uc_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      lc_q      <= lc_d;
      uc_q      <= uc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    med_q  <= med_d;
    held_q <= held_d;
    drop_q <= drop_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutW'({held_q, med_q});
  assign m_axis_tuser  = drop_q;

endmodule

// ----- rtl/rmth_checker.sv -----
// Port-level checks for the running median block, bound to the top level
`include "running_median_two_heaps_assert.svh"

module rmth_checker #(
  parameter int unsigned CAPACITY     = rmth_pkg::CapacityDef,
  parameter int unsigned SAMPLE_WIDTH = rmth_pkg::SampleWidthDef
) (
  input logic                                                 clk_i,
  input logic                                                 rst_ni,
  input logic                                                 s_axis_tvalid,
  input logic                                                 s_axis_tready,
  input logic                                                 s_axis_tuser,
  input logic                                                 m_axis_tvalid,
  input logic                                                 m_axis_tready,
  input logic [((SAMPLE_WIDTH+rmth_pkg::HeldWidth+7)/8)*8-1:0] m_axis_tdata,
  input logic                                                 m_axis_tuser
);
  import rmth_pkg::*;

  localparam logic [HeldWidth-1:0] HeldCap = HeldWidth'(CAPACITY);

  logic [HeldWidth-1:0] held;
  logic                 in_xfer;

  assign held    = m_axis_tdata[SAMPLE_WIDTH +: HeldWidth];
  assign in_xfer = s_axis_tvalid & s_axis_tready;

  `RMTH_ASSERT_NEXT(a_restart_holds_one, in_xfer && s_axis_tuser, m_axis_tvalid && held == HeldWidth'(1) && !m_axis_tuser)
  `RMTH_ASSERT_NOW(a_drop_only_when_full, m_axis_tvalid && m_axis_tuser, held == HeldCap)
  `RMTH_ASSERT_NEXT(a_result_follows_transfer, in_xfer, m_axis_tvalid)
  `RMTH_ASSERT_NEXT(a_stall_holds_result, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind running_median_two_heaps rmth_checker #(
  .CAPACITY     (CAPACITY),
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rmth_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the running median block: random stream traffic against a sorted-window predictor
`timescale 1ns / 1ps

module tb_top;
  import rmth_pkg::*;

  localparam int SW          = SampleWidthDef;
  localparam int CAP         = CapacityDef;
  localparam int HW          = HeldWidth;
  localparam int IN_W        = ((SW + 7) / 8) * 8;
  localparam int OUT_W       = ((SW + HW + 7) / 8) * 8;
  localparam int RUN_ITEMS   = 900;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_SHOWN   = 10;

  localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};

  typedef struct packed {
    logic signed [SW-1:0] value;
    logic                 restart;
  } sample_t;

  typedef struct packed {
    logic signed [SW-1:0] median;
    logic [HW-1:0]        held;
    logic                 dropped;
  } median_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             s_axis_tuser  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;

  sample_t              pending_samples[$];
  median_t              medians_due[$];
  logic signed [SW-1:0] window[CAP];
  int                   window_n   = 0;
  int                   mismatches = 0;
  int                   in_gap     = 0;
  int                   out_stall  = 0;
  int                   quiet      = 0;
  bit                   in_calm    = 1'b0;
  bit                   out_calm   = 1'b0;

  running_median_two_heaps dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // keep the held samples sorted; the lower median sits at index (n-1)/2
  function automatic median_t track_sample(sample_t s);
    median_t r;
    int      pos;
    if (s.restart) window_n = 0;
    r.dropped = 1'b0;
    if (window_n >= CAP) begin
      r.dropped = 1'b1;
    end else begin
      pos = window_n;
      while (pos > 0 && $signed(window[pos-1]) > $signed(s.value)) begin
        window[pos] = window[pos-1];
        pos--;
      end
      window[pos] = s.value;
      window_n++;
    end
    r.median = window[(window_n - 1) / 2];
    r.held   = HW'(window_n);
    return r;
  endfunction

  function automatic int next_gap(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SW-1:0] pick_value();
    int tmp;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return SMIN;
          1: return SMAX;
          2: return '1;
          default: return '0;
        endcase
      end
      1, 2: begin
        tmp = $urandom_range(0, 16);
        return SW'(tmp - 8);
      end
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic queue_item(logic [SW-1:0] v, bit rs);
    sample_t item;
    item.value   = v;
    item.restart = rs;
    pending_samples.insert(pending_samples.size(), item);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      in_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        medians_due.insert(medians_due.size(),
                           track_sample('{value: s_axis_tdata[SW-1:0],
                                          restart: s_axis_tuser}));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          nxt = pending_samples.pop_front();
          s_axis_tdata  <= IN_W'($unsigned(nxt.value));
          s_axis_tuser  <= nxt.restart;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 59) == 0) in_calm = !in_calm;
          in_gap = next_gap(in_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    median_t want;
    median_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.median  = m_axis_tdata[SW-1:0];
        got.held    = m_axis_tdata[SW +: HW];
        got.dropped = m_axis_tuser;
        if (medians_due.size() == 0) begin
          if (mismatches < MAX_SHOWN)
            $display("unexpected transfer: median=%0d held=%0d dropped=%0b",
                     got.median, got.held, got.dropped);
          mismatches++;
        end else begin
          want = medians_due.pop_front();
          if (got.median !== want.median || got.held !== want.held ||
              got.dropped !== want.dropped) begin
            if (mismatches < MAX_SHOWN)
              $display("mismatch: expected median=%0d held=%0d dropped=%0b, got median=%0d held=%0d dropped=%0b",
                       want.median, want.held, want.dropped,
                       got.median, got.held, got.dropped);
            mismatches++;
          end
        end
        if ($urandom_range(0, 59) == 0) out_calm = !out_calm;
      end
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_stall = next_gap(out_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= STALL_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int len;
    queue_item(SW'(5), 1'b0);
    queue_item(SMAX, 1'b0);
    queue_item(SMIN, 1'b0);
    queue_item('1, 1'b0);
    queue_item(SW'(1), 1'b0);
    queue_item(SMIN, 1'b0);
    queue_item(SMAX, 1'b0);
    queue_item('0, 1'b0);
    queue_item('0, 1'b0);
    queue_item('0, 1'b0);
    queue_item(SMIN, 1'b1);
    queue_item(SMIN, 1'b0);
    queue_item(SMIN, 1'b0);
    queue_item(SMAX, 1'b1);
    queue_item(SMAX, 1'b0);
    queue_item(SMAX, 1'b0);
    for (int k = 1; k <= 4; k++) queue_item(SW'(k * 100), k == 1);
    queue_item(SW'(-5), 1'b1);
    queue_item(SW'(-10), 1'b0);
    queue_item(SW'(-20), 1'b0);
    queue_item(SW'(-40), 1'b0);

    // fill past capacity, then restart on a full store
    queue_item(pick_value(), 1'b1);
    repeat (CAP + 5) queue_item(pick_value(), 1'b0);
    while (pending_samples.size() < RUN_ITEMS) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(CAP - 4, CAP + 8)
                                         : $urandom_range(1, 40);
      if (len > RUN_ITEMS - pending_samples.size())
        len = RUN_ITEMS - pending_samples.size();
      queue_item(pick_value(), 1'b1);
      repeat (len - 1) queue_item(pick_value(), 1'b0);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_samples.size() > 0 || s_axis_tvalid || medians_due.size() > 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && medians_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
